// File: sv/zstf_pkg.sv
`timescale 1ns / 1ps

package zstf_pkg;

    localparam int MAX_VALUES_DEF   = 32;
    localparam int MAX_TRIPLETS_DEF = 64;
    localparam int VALUE_BITS_DEF   = 16;

    // sequencer states: load, insertion sort, then two search passes
    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_KEY,
        S_SORT_LOAD,
        S_SORT_RD,
        S_SORT_CMP,
        S_I_RD,
        S_I_CHK,
        S_J_RD,
        S_J_CHK,
        S_K_RD,
        S_K_CHK,
        S_HIT,
        S_EMPTY
    } t_state;

endpackage

// File: sv/zero_sum_triplet_finder.sv
`timescale 1ns / 1ps
// operation: one value loaded per cycle while idle; after the tlast transaction an insertion sort
// (worst case n*n element moves), then a counting search pass and, if it found any triplet,
// an emitting pass (worst case order n*n*n reads each), all on one memory port
// throughput: one set at a time, s_axis_tready is high only while loading
// reset: i_rst_n synchronous active low clears the sequencer, counts, flags and the
// output valid; value store contents are left undefined
module zero_sum_triplet_finder
    import zstf_pkg::*;
#(
    parameter int MAX_VALUES   = MAX_VALUES_DEF,
    parameter int MAX_TRIPLETS = MAX_TRIPLETS_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF,
    localparam int IN_W  = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * VALUE_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // sample
    input  logic             s_axis_tlast,   // end_of_set
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // first, second, third
    output logic [2:0]       m_axis_tuser,   // found, dropped, overflow
    output logic             m_axis_tlast    // final_res
);

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam int TW = $clog2(MAX_TRIPLETS + 1);
    localparam int NW = VALUE_BITS + 2;

    // value store, one write and one registered read per cycle
    logic signed [VALUE_BITS-1:0] r_mem [MAX_VALUES];
    logic signed [VALUE_BITS-1:0] r_rdata;
    logic                         mem_we;
    logic [AW-1:0]                mem_wa, mem_ra;
    logic signed [VALUE_BITS-1:0] mem_wd;

    t_state r_state, n_state;

    // control registers
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_drop, n_drop;
    logic          r_pass, n_pass;
    logic          r_ovf, n_ovf;
    logic [TW-1:0] r_tcount, n_tcount;
    logic [TW-1:0] r_emit, n_emit;
    logic          r_m_valid;

    // datapath registers
    logic [CW-1:0]                r_i, n_i, r_j, n_j, r_k, n_k;
    logic signed [VALUE_BITS-1:0] r_key, n_key, r_ai, n_ai, r_aj, n_aj;
    logic signed [NW-1:0]         r_need, n_need;

    logic signed [VALUE_BITS-1:0] r_o_first, r_o_second, r_o_third;
    logic                         r_o_found, r_o_ovf, r_o_drop, r_o_final;

    logic                         in_acc, out_free, out_load, load_found, load_final;
    logic signed [VALUE_BITS-1:0] in_sample;
    logic [CW:0]                  i_p2, j_p1;
    logic signed [NW-1:0]         sum_ij, need_ij, rdata_x;
    logic                         i_end, last_hit;

    assign in_sample = s_axis_tdata[VALUE_BITS-1:0];
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_m_valid || m_axis_tready;

    assign i_p2    = {1'b0, r_i} + (CW+1)'(2);
    assign j_p1    = {1'b0, r_j} + (CW+1)'(1);
    // search pass ends when i runs out, or after an overflow on the counting pass
    assign i_end   = (i_p2 >= {1'b0, r_cnt}) || (!r_pass && r_ovf);
    assign sum_ij  = NW'(r_ai) + NW'(r_rdata);
    assign need_ij = -sum_ij;
    assign rdata_x = NW'(r_rdata);
    assign last_hit = (r_emit == r_tcount - TW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && s_axis_tlast) n_state = S_SORT_KEY;
            end
            S_SORT_KEY: begin
                n_state = (r_i >= r_cnt) ? S_I_RD : S_SORT_LOAD;
            end
            S_SORT_LOAD: n_state = S_SORT_RD;
            S_SORT_RD: begin
                n_state = (r_j == '0) ? S_SORT_KEY : S_SORT_CMP;
            end
            S_SORT_CMP: begin
                n_state = (r_rdata > r_key) ? S_SORT_RD : S_SORT_KEY;
            end
            S_I_RD: begin
                if (!i_end)                  n_state = S_I_CHK;
                else if (r_pass)             n_state = S_IDLE;
                else if (r_tcount == '0)     n_state = S_EMPTY;
                else                         n_state = S_I_RD;
            end
            S_I_CHK: begin
                if (r_i != '0 && r_rdata == r_ai) n_state = S_I_RD;
                else                              n_state = S_J_RD;
            end
            S_J_RD: begin
                n_state = (j_p1 >= {1'b0, r_cnt}) ? S_I_RD : S_J_CHK;
            end
            S_J_CHK: begin
                if (r_j > r_i + CW'(1) && r_rdata == r_aj) n_state = S_J_RD;
                else if (need_ij < rdata_x)                n_state = S_I_RD;
                else                                       n_state = S_K_RD;
            end
            S_K_RD: begin
                n_state = (r_k >= r_cnt) ? S_J_RD : S_K_CHK;
            end
            S_K_CHK: begin
                if (rdata_x == r_need)     n_state = S_HIT;
                else if (rdata_x > r_need) n_state = S_J_RD;
                else                       n_state = S_K_RD;
            end
            S_HIT: begin
                if (!r_pass) begin
                    n_state = (r_tcount == TW'(MAX_TRIPLETS)) ? S_I_RD : S_J_RD;
                end else if (out_free) begin
                    n_state = last_hit ? S_IDLE : S_J_RD;
                end
            end
            S_EMPTY: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_cnt    = r_cnt;
        n_drop   = r_drop;
        n_pass   = r_pass;
        n_ovf    = r_ovf;
        n_tcount = r_tcount;
        n_emit   = r_emit;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_key    = r_key;
        n_ai     = r_ai;
        n_aj     = r_aj;
        n_need   = r_need;
        mem_we   = 1'b0;
        mem_wa   = r_cnt[AW-1:0];
        mem_wd   = in_sample;
        mem_ra   = r_i[AW-1:0];
        out_load   = 1'b0;
        load_found = 1'b0;
        load_final = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_cnt < CW'(MAX_VALUES)) begin
                        mem_we = 1'b1;
                        n_cnt  = r_cnt + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_i      = CW'(1);
                        n_pass   = 1'b0;
                        n_ovf    = 1'b0;
                        n_tcount = '0;
                        n_emit   = '0;
                    end
                end
            end
            S_SORT_KEY: begin
                mem_ra = r_i[AW-1:0];
                if (r_i >= r_cnt) n_i = '0;
            end
            S_SORT_LOAD: begin
                n_key = r_rdata;
                n_j   = r_i;
            end
            S_SORT_RD: begin
                mem_ra = AW'(r_j - CW'(1));
                if (r_j == '0) begin
                    mem_we = 1'b1;
                    mem_wa = '0;
                    mem_wd = r_key;
                    n_i    = r_i + CW'(1);
                end
            end
            S_SORT_CMP: begin
                mem_we = 1'b1;
                mem_wa = r_j[AW-1:0];
                if (r_rdata > r_key) begin
                    mem_wd = r_rdata;
                    n_j    = r_j - CW'(1);
                end else begin
                    mem_wd = r_key;
                    n_i    = r_i + CW'(1);
                end
            end
            S_I_RD: begin
                mem_ra = r_i[AW-1:0];
                if (i_end) begin
                    if (r_pass) begin
                        n_cnt  = '0;
                        n_drop = 1'b0;
                    end else if (r_tcount != '0) begin
                        n_pass = 1'b1;
                        n_i    = '0;
                    end
                end
            end
            S_I_CHK: begin
                n_ai = r_rdata;
                if (r_i != '0 && r_rdata == r_ai) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_i + CW'(1);
                end
            end
            S_J_RD: begin
                mem_ra = r_j[AW-1:0];
                if (j_p1 >= {1'b0, r_cnt}) n_i = r_i + CW'(1);
            end
            S_J_CHK: begin
                n_aj = r_rdata;
                if (r_j > r_i + CW'(1) && r_rdata == r_aj) begin
                    n_j = r_j + CW'(1);
                end else if (need_ij < rdata_x) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_need = need_ij;
                    n_k    = r_j + CW'(1);
                end
            end
            S_K_RD: begin
                mem_ra = r_k[AW-1:0];
                if (r_k >= r_cnt) n_j = r_j + CW'(1);
            end
            S_K_CHK: begin
                if (rdata_x > r_need)       n_j = r_j + CW'(1);
                else if (rdata_x != r_need) n_k = r_k + CW'(1);
            end
            S_HIT: begin
                if (!r_pass) begin
                    if (r_tcount == TW'(MAX_TRIPLETS)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_tcount = r_tcount + TW'(1);
                        n_j      = r_j + CW'(1);
                    end
                end else if (out_free) begin
                    out_load   = 1'b1;
                    load_found = 1'b1;
                    load_final = last_hit;
                    n_emit     = r_emit + TW'(1);
                    n_j        = r_j + CW'(1);
                    if (last_hit) begin
                        n_cnt  = '0;
                        n_drop = 1'b0;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    load_final = 1'b1;
                    n_cnt      = '0;
                    n_drop     = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_pass    <= 1'b0;
            r_ovf     <= 1'b0;
            r_tcount  <= '0;
            r_emit    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_drop   <= n_drop;
            r_pass   <= n_pass;
            r_ovf    <= n_ovf;
            r_tcount <= n_tcount;
            r_emit   <= n_emit;
            if (out_load)           r_m_valid <= 1'b1;
            else if (m_axis_tready) r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_key  <= n_key;
        r_ai   <= n_ai;
        r_aj   <= n_aj;
        r_need <= n_need;
        // output register, empty answer carries zeros and no overflow
        if (out_load) begin
            r_o_first  <= load_found ? r_ai : '0;
            r_o_second <= load_found ? r_aj : '0;
            r_o_third  <= load_found ? r_need[VALUE_BITS-1:0] : '0;
            r_o_found  <= load_found;
            r_o_ovf    <= load_found && r_ovf;
            r_o_drop   <= r_drop;
            r_o_final  <= load_final;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_W'({r_o_third, r_o_second, r_o_first});
    assign m_axis_tuser  = {r_o_ovf, r_o_drop, r_o_found};
    assign m_axis_tlast  = r_o_final;

endmodule

// File: sv/zstf_checker.sv
`timescale 1ns / 1ps

module zstf_checker
    import zstf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int OUT_W = ((3 * VALUE_BITS + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic [2:0]       m_axis_tuser,
    input logic             m_axis_tlast
);

    localparam int NW = VALUE_BITS + 2;

    logic signed [NW-1:0] sum3;
    assign sum3 = NW'($signed(m_axis_tdata[VALUE_BITS-1:0]))
                + NW'($signed(m_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]))
                + NW'($signed(m_axis_tdata[3*VALUE_BITS-1:2*VALUE_BITS]));

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // search starts after the last value, input closes
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input open during search");

    // reported triplets sum to zero
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> sum3 == '0)
        else $error("triplet sum nonzero");

    // empty answer is a single final transaction without overflow
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && !m_axis_tuser[2]
        && m_axis_tdata == '0)
        else $error("bad empty answer");

endmodule

bind zero_sum_triplet_finder zstf_checker #(.VALUE_BITS(VALUE_BITS)) u_zstf_checker (.*);

// File: test/zero_sum_triplet_finder_tb.sv
`timescale 1ns / 1ps

module zero_sum_triplet_finder_tb;
    import zstf_pkg::*;

    localparam int DEPTH    = MAX_VALUES_DEF;
    localparam int CAP      = MAX_TRIPLETS_DEF;
    localparam int WD_LIMIT = 800000;

    typedef struct packed {
        logic [15:0] first;
        logic [15:0] second;
        logic [15:0] third;
        logic        found;
        logic        dropped;
        logic        overflow;
        logic        final_res;
    } t_triplet;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // sample
    logic        s_axis_tlast = 1'b0; // end_of_set
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // first, second, third
    logic [2:0]  m_axis_tuser;        // found, dropped, overflow
    logic        m_axis_tlast;        // final_res

    zero_sum_triplet_finder dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_triplet  triplet_q[$];
    int        set_vals[$];
    bit        set_dropped;
    int        err_count;
    int        src_idle;
    int        snk_idle;
    int        hold_cnt;
    int        wd_cnt;
    int        items_sent;

    // predictor: mirror of store, sort and search for one finished set
    function automatic void predict_triplets();
        int a[DEPTH];
        int n, i, j, k, key, need, cnt;
        bit ovf, hit;
        int trip[CAP][3];
        t_triplet r;
        n = set_vals.size();
        cnt = 0;
        ovf = 0;
        for (i = 0; i < n; i++) a[i] = set_vals[i];
        for (i = 1; i < n; i++) begin
            key = a[i];
            j = i;
            while (j > 0 && a[j-1] > key) begin
                a[j] = a[j-1];
                j--;
            end
            a[j] = key;
        end
        for (i = 0; i + 2 < n && !ovf; i++) begin
            if (i > 0 && a[i] == a[i-1]) continue;
            for (j = i + 1; j + 1 < n; j++) begin
                if (j > i + 1 && a[j] == a[j-1]) continue;
                need = -(a[i] + a[j]);
                if (need < a[j]) break;
                hit = 0;
                for (k = j + 1; k < n; k++) if (a[k] == need) hit = 1;
                if (hit) begin
                    if (cnt >= CAP) begin
                        ovf = 1;
                        break;
                    end
                    trip[cnt][0] = a[i];
                    trip[cnt][1] = a[j];
                    trip[cnt][2] = need;
                    cnt++;
                end
            end
        end
        if (cnt == 0) begin
            r = '0;
            r.dropped = set_dropped;
            r.final_res = 1'b1;
            triplet_q.insert(triplet_q.size(), r);
        end else begin
            for (i = 0; i < cnt; i++) begin
                r.first = trip[i][0][15:0];
                r.second = trip[i][1][15:0];
                r.third = trip[i][2][15:0];
                r.found = 1'b1;
                r.dropped = set_dropped;
                r.overflow = ovf;
                r.final_res = (i == cnt - 1);
                triplet_q.insert(triplet_q.size(), r);
            end
        end
        set_vals.delete();
        set_dropped = 0;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    // one input transaction; called and returns at a falling edge
    task automatic send_sample(logic [15:0] v, bit last);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (set_vals.size() < DEPTH) set_vals.insert(set_vals.size(), $signed(v));
        else set_dropped = 1;
        items_sent++;
        if (last) predict_triplets();
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
    endtask

    task automatic wait_all_results();
        stop_sending();
        while (triplet_q.size() != 0) @(negedge i_clk);
    endtask

    // mode 0: small values dense in hits, mode 1: full range
    task automatic send_random_set(int n, int mode);
        logic [15:0] v;
        for (int i = 0; i < n; i++) begin
            if (mode == 0) v = 16'($urandom_range(16) - 8);
            else v = 16'($urandom);
            send_sample(v, i == n - 1);
        end
    endtask

    // receiver side: random idling plus a counted hold-off
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_triplet got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                   m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2], m_axis_tlast};
            if (triplet_q.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                exp_r = triplet_q.pop_front();
                if (got.first !== exp_r.first) report_mismatch("first");
                if (got.second !== exp_r.second) report_mismatch("second");
                if (got.third !== exp_r.third) report_mismatch("third");
                if (got.found !== exp_r.found) report_mismatch("found");
                if (got.dropped !== exp_r.dropped) report_mismatch("dropped");
                if (got.overflow !== exp_r.overflow) report_mismatch("overflow");
                if (got.final_res !== exp_r.final_res) report_mismatch("final_res");
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            wd_cnt <= 0;
        end else if (wd_cnt >= WD_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            wd_cnt <= wd_cnt + 1;
        end
    end

    task automatic test_directed();
        send_sample(16'h8000, 0);
        send_sample(16'h7fff, 0);
        send_sample(16'h0001, 1);
        send_sample(16'h0000, 1);
        send_sample(16'hffff, 0);
        send_sample(16'h0001, 1);
        send_sample(16'h0001, 0);
        send_sample(16'h0002, 0);
        send_sample(16'h0003, 1);
        send_sample(16'h0000, 0);
        send_sample(16'h0000, 0);
        send_sample(16'h0000, 1);
        send_sample(16'hffff, 0);
        send_sample(16'h0000, 0);
        send_sample(16'h0001, 0);
        send_sample(16'h0002, 0);
        send_sample(16'hffff, 0);
        send_sample(16'hfffc, 1);
        wait_all_results();
    endtask

    task automatic test_drop();
        send_random_set(DEPTH + 3, 0);
        wait_all_results();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < DEPTH; i++) send_sample(16'(i - 15), i == DEPTH - 1);
        wait_all_results();
    endtask

    task automatic test_backpressure();
        hold_cnt = 400;
        send_random_set(6, 0);
        send_random_set(5, 0);
        send_random_set(4, 0);
        wait_all_results();
    endtask

    task automatic test_random(int goal);
        int r;
        while (items_sent < goal) begin
            r = $urandom_range(99);
            if (r < 8) send_random_set($urandom_range(2, 1), 1);
            else if (r < 25) send_random_set($urandom_range(8, 3), 1);
            else send_random_set($urandom_range(9, 3), 0);
        end
        wait_all_results();
    endtask

    initial begin
        err_count = 0;
        src_idle = 0;
        snk_idle = 0;
        hold_cnt = 0;
        wd_cnt = 0;
        items_sent = 0;
        set_dropped = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        src_idle = 29;
        snk_idle = 60;
        test_directed();
        test_drop();
        test_backpressure();
        test_random(items_sent + 85);
        src_idle = 60;
        snk_idle = 29;
        test_overflow();
        test_random(items_sent + 85);
        src_idle = 0;
        snk_idle = 0;
        test_random(items_sent + 20);
        repeat (50) @(posedge i_clk);
        if (err_count == 0 && triplet_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
sv/zstf_pkg.sv
sv/zero_sum_triplet_finder.sv
sv/zstf_checker.sv
test/zero_sum_triplet_finder_tb.sv
